@@ src/ehabi_pkg.sv @@
// Shared types and codes for the EHABI unwind opcode decoder.
package ehabi_pkg;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MORE     = 3'd1;
    localparam logic [2:0] ST_FINISH   = 3'd2;
    localparam logic [2:0] ST_REFUSE   = 3'd3;
    localparam logic [2:0] ST_RESERVED = 3'd4;
    localparam logic [2:0] ST_SPARE    = 3'd5;
    localparam logic [2:0] ST_TRUNC    = 3'd6;

    localparam logic [3:0] PK_NONE    = 4'd0;
    localparam logic [3:0] PK_CORE_HI = 4'd1;
    localparam logic [3:0] PK_CORE_LO = 4'd2;
    localparam logic [3:0] PK_ULEB    = 4'd3;
    localparam logic [3:0] PK_VFPX    = 4'd4;
    localparam logic [3:0] PK_WR      = 4'd5;
    localparam logic [3:0] PK_WCGR    = 4'd6;
    localparam logic [3:0] PK_VFP16   = 4'd7;
    localparam logic [3:0] PK_VFP     = 4'd8;

    localparam logic [31:0] ULEB_BASE = 32'h204;
    localparam logic [5:0]  ULEB_SHIFT_MAX = 6'd35;
    localparam logic [5:0]  ULEB_SHIFT_LIMIT = 6'd32;

    // The ULEB128 field holds vsp + 0x204 + 4 * accumulated value.
    typedef struct packed {
        logic [31:0] sp;
        logic [3:0]  pk;
        logic [3:0]  mh;
        logic [31:0] ul;
        logic [5:0]  sh;
        logic [2:0]  st;
    } t_unw_state;

    typedef struct packed {
        logic        wr_en;
        logic [3:0]  wr_idx;
        logic [31:0] wr_data;
        logic [15:0] clr_mask;
        logic        fin;
    } t_rf_ctrl;

endpackage

@@ src/ehabi_regfile.sv @@
// Core register file with write, pop clear and finish copy of lr to pc when pc is zero.
module ehabi_regfile (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  ehabi_pkg::t_rf_ctrl i_ctrl,
    input  logic [3:0]          i_rd_idx,
    output logic [31:0]         o_rd_data,
    output logic [31:0]         o_r14,
    output logic [31:0]         o_r15
);
    import ehabi_pkg::*;

    logic [31:0] r_regs [16];
    logic [31:0] n_regs [16];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            n_regs[i] = r_regs[i];
            if (i_ctrl.wr_en && (i_ctrl.wr_idx == 4'(i))) begin
                n_regs[i] = i_ctrl.wr_data;
            end else if (i_ctrl.clr_mask[i]) begin
                n_regs[i] = '0;
            end else if ((i == 15) && i_ctrl.fin && (r_regs[15] == '0)) begin
                n_regs[i] = r_regs[14];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 16; i++) begin
            if (!i_rst_n) begin
                r_regs[i] <= '0;
            end else if (i_en) begin
                r_regs[i] <= n_regs[i];
            end
        end
    end

    assign o_rd_data = r_regs[i_rd_idx];
    assign o_r14     = r_regs[14];
    assign o_r15     = r_regs[15];

endmodule

@@ src/ehabi_exec.sv @@
// Decode and execute of one item against the current unwind state.
module ehabi_exec (
    input  logic [1:0]            i_action,
    input  logic [7:0]            i_opcode_byte,
    input  logic                  i_last_byte,
    input  logic [3:0]            i_reg_index,
    input  logic [31:0]           i_reg_value,
    input  ehabi_pkg::t_unw_state i_state,
    input  logic [31:0]           i_rd_data,
    input  logic [31:0]           i_r14,
    input  logic [31:0]           i_r15,
    output ehabi_pkg::t_unw_state o_state,
    output ehabi_pkg::t_rf_ctrl   o_rf,
    output logic [15:0]           o_popped_mask,
    output logic [31:0]           o_pc_value
);
    import ehabi_pkg::*;

    localparam logic [2:0] SP_KEEP = 3'd0;
    localparam logic [2:0] SP_ADD  = 3'd1;
    localparam logic [2:0] SP_SUB  = 3'd2;
    localparam logic [2:0] SP_REG  = 3'd3;
    localparam logic [2:0] SP_ULEB = 3'd4;
    localparam logic [2:0] SP_VAL  = 3'd5;

    localparam logic [1:0] UL_KEEP = 2'd0;
    localparam logic [1:0] UL_ZERO = 2'd1;
    localparam logic [1:0] UL_SUM  = 2'd2;
    localparam logic [1:0] UL_BASE = 2'd3;

    logic [7:0]  b;
    logic [3:0]  lo4;
    logic [2:0]  lo3;
    logic        use_first;
    logic [31:0] uleb_shifted;
    logic [31:0] uleb_add;
    logic [31:0] uleb_sum;
    logic [5:0]  sh_step;
    logic [31:0] sp_plus;
    logic [31:0] sp_minus;
    logic [31:0] delta;
    logic [2:0]  sp_op;
    logic [1:0]  ul_op;
    logic [15:0] mask;
    logic        pop_en;
    logic [2:0]  st;
    logic [4:0]  pop_words;
    t_unw_state  n;
    t_rf_ctrl    rf;

    assign b         = i_opcode_byte;
    assign lo4       = b[3:0];
    assign lo3       = b[2:0];
    assign use_first = (i_state.pk == PK_NONE) || (i_state.pk > PK_VFP);

    assign uleb_shifted = {25'd0, b[6:0]} << i_state.sh[4:0];
    assign uleb_add     = (i_state.sh < ULEB_SHIFT_LIMIT) ? {uleb_shifted[29:0], 2'b00} : '0;
    assign uleb_sum     = i_state.ul + uleb_add;
    assign sh_step      = ((i_state.sh + 6'd7) > ULEB_SHIFT_MAX) ? ULEB_SHIFT_MAX
                                                                 : i_state.sh + 6'd7;
    assign pop_words    = 5'($countones(mask));

    always_comb begin
        n      = i_state;
        rf     = '0;
        sp_op  = SP_KEEP;
        ul_op  = UL_KEEP;
        delta  = '0;
        mask   = '0;
        pop_en = 1'b0;
        st     = i_state.st;
        unique case (i_action)
            ACT_BYTE: begin
                if (i_state.st < ST_FINISH) begin
                    n.pk = PK_NONE;
                    st   = ST_OK;
                    if (use_first) begin
                        unique case (b[7:6])
                            2'd0: begin
                                sp_op = SP_ADD;
                                delta = 32'({b[5:0], 2'b00}) + 32'd4;
                            end
                            2'd1: begin
                                sp_op = SP_SUB;
                                delta = 32'({b[5:0], 2'b00}) + 32'd4;
                            end
                            2'd2: begin
                                unique case (b[5:4])
                                    2'd0: begin
                                        n.mh = lo4;
                                        n.pk = PK_CORE_HI;
                                        st   = ST_MORE;
                                    end
                                    2'd1: begin
                                        if (lo4 == 4'd13 || lo4 == 4'd15) begin
                                            st = ST_RESERVED;
                                        end else begin
                                            sp_op = SP_REG;
                                        end
                                    end
                                    2'd2: begin
                                        for (int i = 0; i < 8; i++) begin
                                            mask[4 + i] = (3'(i) <= lo3);
                                        end
                                        mask[14] = mask[14] | b[3];
                                        pop_en   = 1'b1;
                                    end
                                    default: begin
                                        priority if (lo4 == 4'd0) begin
                                            rf.fin = 1'b1;
                                            st     = ST_FINISH;
                                        end else if (lo4 == 4'd1) begin
                                            n.pk = PK_CORE_LO;
                                            st   = ST_MORE;
                                        end else if (lo4 == 4'd2) begin
                                            delta = ULEB_BASE;
                                            ul_op = UL_BASE;
                                            n.sh  = '0;
                                            n.pk  = PK_ULEB;
                                            st    = ST_MORE;
                                        end else if (lo4 == 4'd3) begin
                                            n.pk = PK_VFPX;
                                            st   = ST_MORE;
                                        end else if (lo4[3:2] == 2'd1) begin
                                            st = ST_SPARE;
                                        end else begin
                                            sp_op = SP_ADD;
                                            delta = 32'({lo3, 3'b000}) + 32'd12;
                                        end
                                    end
                                endcase
                            end
                            default: begin
                                unique case (b[5:3])
                                    3'd0: begin
                                        if (lo3 == 3'd6) begin
                                            n.pk = PK_WR;
                                            st   = ST_MORE;
                                        end else if (lo3 == 3'd7) begin
                                            n.pk = PK_WCGR;
                                            st   = ST_MORE;
                                        end else begin
                                            sp_op = SP_ADD;
                                            delta = 32'({lo3, 3'b000}) + 32'd8;
                                        end
                                    end
                                    3'd1: begin
                                        if (lo3 == 3'd0) begin
                                            n.pk = PK_VFP16;
                                            st   = ST_MORE;
                                        end else if (lo3 == 3'd1) begin
                                            n.pk = PK_VFP;
                                            st   = ST_MORE;
                                        end else begin
                                            st = ST_SPARE;
                                        end
                                    end
                                    3'd2: begin
                                        sp_op = SP_ADD;
                                        delta = 32'({lo3, 3'b000}) + 32'd8;
                                    end
                                    default: begin
                                        st = ST_SPARE;
                                    end
                                endcase
                            end
                        endcase
                    end else begin
                        unique case (i_state.pk)
                            PK_CORE_HI: begin
                                n.mh = '0;
                                if ({i_state.mh, b} == 12'd0) begin
                                    st = ST_REFUSE;
                                end else begin
                                    mask   = {i_state.mh, b, 4'b0000};
                                    pop_en = 1'b1;
                                end
                            end
                            PK_CORE_LO: begin
                                if (b == 8'd0 || b[7:4] != 4'd0) begin
                                    st = ST_SPARE;
                                end else begin
                                    mask   = {12'd0, lo4};
                                    pop_en = 1'b1;
                                end
                            end
                            PK_ULEB: begin
                                if (b[7]) begin
                                    ul_op = UL_SUM;
                                    n.sh  = sh_step;
                                    n.pk  = PK_ULEB;
                                    st    = ST_MORE;
                                end else begin
                                    sp_op = SP_ULEB;
                                    ul_op = UL_ZERO;
                                    n.sh  = '0;
                                end
                            end
                            PK_VFPX: begin
                                sp_op = SP_ADD;
                                delta = 32'({lo4, 3'b000}) + 32'd12;
                            end
                            PK_WCGR: begin
                                if (b == 8'd0 || b[7:4] != 4'd0) begin
                                    st = ST_SPARE;
                                end else begin
                                    sp_op = SP_ADD;
                                    delta = 32'({3'($countones(lo4)), 2'b00});
                                end
                            end
                            PK_WR, PK_VFP16, PK_VFP: begin
                                sp_op = SP_ADD;
                                delta = 32'({lo4, 3'b000}) + 32'd8;
                            end
                            default: begin
                                st = i_state.st;
                            end
                        endcase
                    end
                    if (pop_en) begin
                        sp_op       = SP_ADD;
                        delta       = 32'({pop_words, 2'b00});
                        rf.clr_mask = mask;
                    end
                    if (st == ST_MORE && i_last_byte) begin
                        st    = ST_TRUNC;
                        n.pk  = PK_NONE;
                        n.mh  = '0;
                        ul_op = UL_ZERO;
                        n.sh  = '0;
                    end
                    n.st = st;
                end
            end
            ACT_WRITE: begin
                rf.wr_en   = 1'b1;
                rf.wr_idx  = i_reg_index;
                rf.wr_data = i_reg_value;
            end
            ACT_START: begin
                sp_op = SP_VAL;
                ul_op = UL_ZERO;
                n.st  = ST_OK;
                n.pk  = PK_NONE;
                n.mh  = '0;
                n.sh  = '0;
            end
            default: begin
                n.st = i_state.st;
            end
        endcase
    end

    assign sp_plus  = i_state.sp + delta;
    assign sp_minus = i_state.sp - delta;

    always_comb begin
        o_state = n;
        unique case (sp_op)
            SP_ADD:  o_state.sp = sp_plus;
            SP_SUB:  o_state.sp = sp_minus;
            SP_REG:  o_state.sp = i_rd_data;
            SP_ULEB: o_state.sp = uleb_sum;
            SP_VAL:  o_state.sp = i_reg_value;
            default: o_state.sp = i_state.sp;
        endcase
        unique case (ul_op)
            UL_ZERO: o_state.ul = '0;
            UL_SUM:  o_state.ul = uleb_sum;
            UL_BASE: o_state.ul = sp_plus;
            default: o_state.ul = i_state.ul;
        endcase
    end

    always_comb begin
        if (rf.wr_en && rf.wr_idx == 4'd15) begin
            o_pc_value = rf.wr_data;
        end else if (rf.clr_mask[15]) begin
            o_pc_value = '0;
        end else if (rf.fin && i_r15 == '0) begin
            o_pc_value = i_r14;
        end else begin
            o_pc_value = i_r15;
        end
    end

    assign o_rf          = rf;
    assign o_popped_mask = rf.clr_mask;

endmodule

@@ src/arm_ehabi_unwind_opcode_decoder_top.sv @@
// Top level of the EHABI unwind opcode decoder: input register, execute stage, result register.
//
//   channel | direction | handshake                 | payload
//   input   | in        | i_in_valid / o_in_ready   | action, opcode_byte, last_byte, reg_index,
//           |           |                           | reg_value
//   output  | out       | o_out_valid / i_out_ready | status, vsp, pc_value, popped_mask
//
// One item per cycle is sustained while the output is not stalled; each item is held in the input register
// and its result in the result register. The execute stage updates vsp, the register file and the opcode state.
// Reset clears the unwind state, both registers' valid flags and the register file.
// A stalled output holds the result register; one more item waits in the input register.
module arm_ehabi_unwind_opcode_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_opcode_byte,
    input  logic        i_last_byte,
    input  logic [3:0]  i_reg_index,
    input  logic [31:0] i_reg_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_vsp,
    output logic [31:0] o_pc_value,
    output logic [15:0] o_popped_mask
);
    import ehabi_pkg::*;

    logic        r_in_valid;
    logic [1:0]  r_action;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [3:0]  r_idx;
    logic [31:0] r_val;
    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [31:0] r_vsp;
    logic [31:0] r_pc;
    logic [15:0] r_popped;
    t_unw_state  r_state;
    t_unw_state  n_state;
    t_rf_ctrl    rf_ctrl;
    logic [31:0] rd_data;
    logic [31:0] r14;
    logic [31:0] r15;
    logic [31:0] n_pc;
    logic [15:0] n_popped;
    logic        fire;
    logic        in_xfer;

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_action <= i_action;
            r_byte   <= i_opcode_byte;
            r_last   <= i_last_byte;
            r_idx    <= i_reg_index;
            r_val    <= i_reg_value;
        end
    end

    ehabi_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (fire),
        .i_ctrl    (rf_ctrl),
        .i_rd_idx  (r_byte[3:0]),
        .o_rd_data (rd_data),
        .o_r14     (r14),
        .o_r15     (r15)
    );

    ehabi_exec u_exec (
        .i_action      (r_action),
        .i_opcode_byte (r_byte),
        .i_last_byte   (r_last),
        .i_reg_index   (r_idx),
        .i_reg_value   (r_val),
        .i_state       (r_state),
        .i_rd_data     (rd_data),
        .i_r14         (r14),
        .i_r15         (r15),
        .o_state       (n_state),
        .o_rf          (rf_ctrl),
        .o_popped_mask (n_popped),
        .o_pc_value    (n_pc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= n_state.st;
            r_vsp    <= n_state.sp;
            r_pc     <= n_pc;
            r_popped <= n_popped;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_vsp         = r_vsp;
    assign o_pc_value    = r_pc;
    assign o_popped_mask = r_popped;

endmodule

@@ src/ehabi_checker.sv @@
// Port-level assertions for the EHABI unwind opcode decoder and their binding.
module ehabi_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_in_ready,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  o_status,
    input  logic [31:0] o_vsp,
    input  logic [31:0] o_pc_value,
    input  logic [15:0] o_popped_mask
);
    import ehabi_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid right after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) && $stable(o_vsp)
                                        && $stable(o_pc_value) && $stable(o_popped_mask))
        else $error("Stalled output transfer changed.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("Input stalled while the output is empty.");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_popped_mask != '0) |-> (o_status == ST_OK))
        else $error("Registers popped with a non-ok status.");

    a_pop_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_popped_mask[15] |-> (o_pc_value == '0))
        else $error("Popped pc is not cleared.");

endmodule

bind arm_ehabi_unwind_opcode_decoder_top ehabi_checker u_ehabi_checker (.*);
